[sv/ffha_pkg.sv]
// Shared types, constants and helpers of the first-fit heap allocator.
package ffha_pkg;

    localparam int SEG_NUM     = 64;
    localparam int BLOCK_BYTES = 64;   // power of two
    localparam int HDR_BYTES   = 24;
    localparam int CNT_W       = $clog2(SEG_NUM + 1);

    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE  = 2'd1;
    localparam logic [1:0] FN_INIT  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_FIT     = 3'd1;
    localparam logic [2:0] ST_NOTHING    = 3'd2;
    localparam logic [2:0] ST_BAD_PTR    = 3'd3;
    localparam logic [2:0] ST_BELOW      = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL = 3'd5;
    localparam logic [2:0] ST_NOT_ALLOC  = 3'd6;

    typedef struct packed {
        logic        valid;
        logic        first;   // marks the lowest segment of the list
        logic        used;
        logic [31:0] start;
        logic [31:0] size;
    } t_seg;

    typedef struct packed {
        logic load;
        t_seg seg;
    } t_init;

    localparam t_seg SEG_NONE = '{valid: 1'b0, first: 1'b0, used: 1'b0,
                                  start: 32'd0, size: 32'd0};

    // a's payload ends exactly where b's header starts
    function automatic logic seg_adj(t_seg a, t_seg b);
        logic [32:0] a_end;
        a_end = {1'b0, a.start} + 33'(HDR_BYTES) + {1'b0, a.size};
        return a_end == {1'b0, b.start};
    endfunction

endpackage

[sv/ffha_cell.sv]
// One segment cell of the circulating segment chain.
module ffha_cell
    import ffha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_init i_init,
    input  t_seg  i_next,
    output t_seg  o_seg
);

    t_seg r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.valid <= 1'b0;
        end else if (i_init.load) begin
            r_seg <= i_init.seg;
        end else begin
            r_seg <= i_next;
        end
    end

    assign o_seg = r_seg;

endmodule

[sv/ffha_ctrl.sv]
// Sequencer: watches the chain head, edits the segment stream, returns results.
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_pointer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_address,
    input  logic [31:0] i_heap_start,
    input  logic [31:0] i_heap_end,
    input  t_seg        i_head,
    output t_seg        o_tail,
    output t_init       o_init
);

    typedef enum logic [2:0] {
        S_BOOT, S_IDLE, S_SEEK, S_SCAN, S_INIT, S_DONE
    } t_state;

    localparam logic [32:0] BLK_MASK = 33'(BLOCK_BYTES - 1);

    t_state            r_state, n_state;
    logic [1:0]        r_func, n_func;
    logic [31:0]       r_sz, n_sz;
    logic [31:0]       r_hdr, n_hdr;
    logic              r_range_ok, n_range_ok;
    logic              r_low, n_low;
    logic              r_seen, n_seen;
    logic              r_below, n_below;
    logic              r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_left, n_left;
    t_seg              r_p0, n_p0;
    t_seg              r_p1, n_p1;
    logic [2:0]        r_res_status, n_res_status;
    logic [31:0]       r_res_addr, n_res_addr;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_status, n_out_status;
    logic [31:0]       r_out_addr, n_out_addr;

    logic [32:0]       rnd_sum;
    logic [32:0]       rnd_sz;
    logic              init_ok;

    assign rnd_sum = {1'b0, i_request_bytes} + BLK_MASK;
    assign rnd_sz  = rnd_sum & ~BLK_MASK;
    assign init_ok = {1'b0, i_heap_end} >= ({1'b0, i_heap_start} + 33'(HDR_BYTES));

    always_comb begin
        o_init.load      = (r_state == S_BOOT) || (r_state == S_INIT);
        o_init.seg.valid = init_ok;
        o_init.seg.first = 1'b1;
        o_init.seg.used  = 1'b0;
        o_init.seg.start = i_heap_start;
        o_init.seg.size  = i_heap_end - i_heap_start - 32'(HDR_BYTES);
    end

    always_comb begin
        t_seg        e;
        t_seg        ef;
        t_seg        p1_mod;
        t_seg        a0;
        t_seg        a1;
        t_seg        l_arr [4];
        t_seg        q [3];
        logic [2:0]  nq;
        logic        proc;
        logic        hold;
        logic        decided;
        logic        last;
        logic        match;
        logic [31:0] rem;

        n_state      = r_state;
        n_func       = r_func;
        n_sz         = r_sz;
        n_hdr        = r_hdr;
        n_range_ok   = r_range_ok;
        n_low        = r_low;
        n_seen       = r_seen;
        n_below      = r_below;
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;

        e       = i_head;
        ef      = i_head;
        ef.used = 1'b0;
        p1_mod  = r_p1;
        a0      = e;
        a1      = SEG_NONE;
        decided = 1'b0;
        match   = 1'b0;
        rem     = e.size - r_sz;
        proc    = ((r_state == S_SEEK) && e.valid && e.first && !r_p0.valid)
               || ((r_state == S_SCAN) && e.valid);
        hold    = (r_state == S_SCAN) || proc;
        last    = (r_left == CNT_W'(1));

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_BOOT: begin
                n_cnt   = CNT_W'(init_ok);
                n_state = S_IDLE;
            end
            S_INIT: begin
                n_cnt        = CNT_W'(init_ok);
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func       = i_func;
                    n_sz         = rnd_sz[31:0];
                    n_low        = i_pointer < 32'(HDR_BYTES);
                    n_hdr        = i_pointer - 32'(HDR_BYTES);
                    n_range_ok   = (i_pointer != 32'd0) && (i_pointer >= i_heap_start)
                                && (i_pointer <= i_heap_end);
                    n_seen       = 1'b0;
                    n_below      = 1'b0;
                    n_phase      = 1'b0;
                    n_left       = r_cnt;
                    n_res_status = ST_OK;
                    n_res_addr   = 32'd0;
                    case (i_func)
                        FN_ALLOC: begin
                            if (rnd_sz[32] || r_cnt == '0) begin
                                n_res_status = ST_NO_FIT;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SEEK;
                            end
                        end
                        FN_FREE: begin
                            if (r_cnt == '0) begin
                                n_res_status = ST_NOTHING;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SEEK;
                            end
                        end
                        FN_INIT: n_state = S_INIT;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SEEK, S_SCAN: begin
                if (proc) begin
                    n_state = S_SCAN;
                    n_left  = r_left - CNT_W'(1);
                    if (r_func == FN_ALLOC) begin
                        if (!e.used && e.size >= r_sz) begin
                            decided    = 1'b1;
                            n_res_addr = e.start + 32'(HDR_BYTES);
                            if (rem > 32'(HDR_BYTES)) begin
                                if (r_cnt >= CNT_W'(SEG_NUM)) begin
                                    n_res_status = ST_TABLE_FULL;
                                    n_res_addr   = 32'd0;
                                end else begin
                                    a0.used  = 1'b1;
                                    a0.size  = r_sz;
                                    a1.valid = 1'b1;
                                    a1.start = e.start + 32'(HDR_BYTES) + r_sz;
                                    a1.size  = rem - 32'(HDR_BYTES);
                                    n_cnt    = r_cnt + CNT_W'(1);
                                end
                            end else begin
                                a0.used = 1'b1;
                            end
                        end else if (last) begin
                            decided      = 1'b1;
                            n_res_status = ST_NO_FIT;
                        end
                    end else begin
                        if (e.used && !r_seen) begin
                            n_seen  = 1'b1;
                            n_below = r_low || (r_hdr < e.start);
                        end
                        if (!r_phase) begin
                            match = e.used && r_range_ok && !r_low && (e.start == r_hdr);
                            if (match) begin
                                n_phase = 1'b1;
                                // merge into the free predecessor
                                if (r_p1.valid && !r_p1.used && !e.first && seg_adj(r_p1, e)) begin
                                    p1_mod.size = r_p1.size + 32'(HDR_BYTES) + e.size;
                                    a0          = SEG_NONE;
                                    n_cnt       = r_cnt - CNT_W'(1);
                                end else begin
                                    a0 = ef;
                                end
                            end
                            if (last) begin
                                decided = 1'b1;
                                if (match) begin
                                    n_res_status = ST_OK;
                                end else if (!(r_seen || e.used)) begin
                                    n_res_status = ST_NOTHING;
                                end else if (!r_range_ok) begin
                                    n_res_status = ST_BAD_PTR;
                                end else if (r_low || (r_seen ? r_below : (r_hdr < e.start))) begin
                                    n_res_status = ST_BELOW;
                                end else begin
                                    n_res_status = ST_NOT_ALLOC;
                                end
                            end
                        end else begin
                            // segment after the freed one
                            decided = 1'b1;
                            if (!e.used && seg_adj(r_p1, e)) begin
                                p1_mod.size = r_p1.size + 32'(HDR_BYTES) + e.size;
                                a0          = SEG_NONE;
                                n_cnt       = r_cnt - CNT_W'(1);
                            end
                        end
                    end
                    if (decided) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // pack pending words and appended words, oldest first
        l_arr[0] = r_p0;
        l_arr[1] = p1_mod;
        l_arr[2] = a0;
        l_arr[3] = a1;
        q[0]     = SEG_NONE;
        q[1]     = SEG_NONE;
        q[2]     = SEG_NONE;
        nq       = 3'd0;
        for (int j = 0; j < 4; j++) begin
            if (l_arr[j].valid && nq < 3'd3) begin
                q[nq[1:0]] = l_arr[j];
                nq         = nq + 3'd1;
            end
        end

        o_tail = SEG_NONE;
        n_p0   = SEG_NONE;
        n_p1   = SEG_NONE;
        if (nq == 3'd3) begin
            o_tail = q[0];
            n_p0   = q[1];
            n_p1   = q[2];
        end else if (nq == 3'd2) begin
            o_tail = q[0];
            n_p1   = q[1];
        end else if (nq == 3'd1) begin
            // keep the predecessor at hand while a scan runs
            if (hold) begin
                n_p1 = q[0];
            end else begin
                o_tail = q[0];
            end
        end
        if (o_init.load) begin
            n_p0 = SEG_NONE;
            n_p1 = SEG_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_out_valid <= 1'b0;
            r_p0.valid  <= 1'b0;
            r_p1.valid  <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_p0        <= n_p0;
            r_p1        <= n_p1;
            r_cnt       <= n_cnt;
        end
        r_func       <= n_func;
        r_sz         <= n_sz;
        r_hdr        <= n_hdr;
        r_range_ok   <= n_range_ok;
        r_low        <= n_low;
        r_seen       <= n_seen;
        r_below      <= n_below;
        r_phase      <= n_phase;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_address   = r_out_addr;

endmodule

[sv/first_fit_heap_allocator.sv]
// Top level: register port, circulating chain of segment cells, sequencer.
//
//  channel  | handshake                      | word
//  ---------+--------------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_stall        | i_func, i_request_bytes, i_pointer
//  output   | o_out_valid / i_out_stall      | o_status, o_address
//  config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// The segment list circulates through SEG_NUM cells, one cell per cycle, and the
// sequencer sees one segment a cycle at the chain head. An alloc or free waits for
// the lowest segment to reach the head and then scans up to one segment per cycle;
// the next input word is taken only once the current one has been finished.
// After reset the boot state loads the list from the heap registers; reinit loads
// it in the init state and then reports its result.
// A result held by i_out_stall does not block taking the next input word.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_pointer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

    logic [31:0] r_heap_start;
    logic [31:0] r_heap_end;
    t_seg        seg   [SEG_NUM];
    t_seg        tail;
    t_init       init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= 32'd65536;
            r_heap_end   <= 32'd131072;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_START: r_heap_start <= pwdata;
                REG_END:   r_heap_end   <= pwdata;
                default:   r_heap_start <= r_heap_start;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_END) ? r_heap_end : r_heap_start;

    for (genvar k = 0; k < SEG_NUM; k++) begin : g_cell
        t_init cell_init;
        t_seg  cell_next;
        assign cell_init.load = init.load;
        assign cell_init.seg  = (k == 0) ? init.seg : SEG_NONE;
        assign cell_next      = (k == SEG_NUM - 1) ? tail : seg[(k + 1) % SEG_NUM];
        ffha_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_init  (cell_init),
            .i_next  (cell_next),
            .o_seg   (seg[k])
        );
    end

    ffha_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_request_bytes (i_request_bytes),
        .i_pointer       (i_pointer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_address       (o_address),
        .i_heap_start    (r_heap_start),
        .i_heap_end      (r_heap_end),
        .i_head          (seg[0]),
        .o_tail          (tail),
        .o_init          (init)
    );

endmodule

[bench/tb_first_fit_heap_allocator.sv]
// Self-checking bench for the first-fit heap allocator: directed table and cases, then random traffic.
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_HEAP_START = 0;
    localparam int REG_HEAP_END   = 1;
    localparam logic [1:0] FN_NOP = 2'd3;   // unused code, no operation
    localparam logic [2:0] ST_ANY = 3'd7;   // table row: take prediction

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_func;
    logic [31:0] i_request_bytes;
    logic [31:0] i_pointer;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [31:0] o_address;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    first_fit_heap_allocator u_dut (.*);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
    } t_reply;

    // predictor state
    logic [31:0] hp_start, hp_end;
    logic [31:0] s_start [SEG_NUM];
    logic [31:0] s_size  [SEG_NUM];
    logic        s_used  [SEG_NUM];
    int          s_count;

    t_reply replies_due[$];
    int     errors;
    int     send_idle_pct, recv_idle_pct;
    bit     recv_hold;
    logic [31:0] live_ptrs[$];

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void heap_rebuild();
        for (int k = 0; k < SEG_NUM; k++) begin
            s_start[k] = '0;
            s_size[k]  = '0;
            s_used[k]  = 1'b0;
        end
        if ({32'd0, hp_end} < {32'd0, hp_start} + HDR_BYTES) begin
            s_count = 0;
        end else begin
            s_start[0] = hp_start;
            s_size[0]  = 32'(64'(hp_end) - 64'(hp_start) - HDR_BYTES);
            s_count    = 1;
        end
    endfunction

    function automatic void seg_drop(int i);
        for (int k = i; k < s_count - 1; k++) begin
            s_start[k] = s_start[k+1];
            s_size[k]  = s_size[k+1];
            s_used[k]  = s_used[k+1];
        end
        s_count--;
    endfunction

    function automatic void seg_merge_next(int i);
        if (i + 1 < s_count && !s_used[i] && !s_used[i+1] &&
            64'(s_start[i]) + HDR_BYTES + 64'(s_size[i]) == 64'(s_start[i+1])) begin
            s_size[i] = 32'(64'(s_size[i]) + HDR_BYTES + 64'(s_size[i+1]));
            seg_drop(i + 1);
        end
    endfunction

    function automatic t_reply heap_apply(logic [1:0] fn, logic [31:0] req, logic [31:0] ptr);
        t_reply r;
        logic [63:0] sz, rem, hdr;
        int i, first;
        r = '0;
        if (fn == FN_ALLOC) begin
            sz = 64'(req);
            if (sz % BLOCK_BYTES != 0) sz += BLOCK_BYTES - (sz % BLOCK_BYTES);
            if (sz > 64'hFFFF_FFFF) begin
                r.status = ST_NO_FIT;
                return r;
            end
            for (i = 0; i < s_count; i++)
                if (!s_used[i] && 64'(s_size[i]) >= sz) break;
            if (i >= s_count) begin
                r.status = ST_NO_FIT;
                return r;
            end
            rem = 64'(s_size[i]) - sz;
            if (rem > HDR_BYTES) begin
                if (s_count >= SEG_NUM) begin
                    r.status = ST_TABLE_FULL;
                    return r;
                end
                for (int k = s_count; k > i + 1; k--) begin
                    s_start[k] = s_start[k-1];
                    s_size[k]  = s_size[k-1];
                    s_used[k]  = s_used[k-1];
                end
                s_start[i+1] = 32'(64'(s_start[i]) + HDR_BYTES + sz);
                s_size[i+1]  = 32'(rem - HDR_BYTES);
                s_used[i+1]  = 1'b0;
                s_size[i]    = 32'(sz);
                s_count++;
            end
            s_used[i] = 1'b1;
            r.address = 32'(64'(s_start[i]) + HDR_BYTES);
        end else if (fn == FN_FREE) begin
            first = s_count;
            for (i = 0; i < s_count; i++)
                if (s_used[i]) begin
                    first = i;
                    break;
                end
            if (first >= s_count) begin
                r.status = ST_NOTHING;
                return r;
            end
            if (ptr == 0 || ptr < hp_start || ptr > hp_end) begin
                r.status = ST_BAD_PTR;
                return r;
            end
            if (ptr < HDR_BYTES || 64'(ptr) - HDR_BYTES < 64'(s_start[first])) begin
                r.status = ST_BELOW;
                return r;
            end
            hdr = 64'(ptr) - HDR_BYTES;
            for (i = first; i < s_count; i++)
                if (s_used[i] && 64'(s_start[i]) == hdr) break;
            if (i >= s_count) begin
                r.status = ST_NOT_ALLOC;
                return r;
            end
            s_used[i] = 1'b0;
            seg_merge_next(i);
            if (i > 0) seg_merge_next(i - 1);
        end else if (fn == FN_INIT) begin
            heap_rebuild();
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected word status=%0d address=%h",
                         $time, o_status, o_address);
                errors++;
            end else begin
                want = replies_due.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                    errors++;
                end
                if (o_address !== want.address) begin
                    $display("%0t: address expected %h actual %h",
                             $time, want.address, o_address);
                    errors++;
                end
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic apb_write(int idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_HEAP_START) hp_start = val;
        else hp_end = val;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(negedge i_clk);
        repeat (3 * SEG_NUM) @(negedge i_clk);
    endtask

    // offer one word; st_fix other than ST_ANY also checks the prediction
    // valid stays up on return; the next word, an idle cycle or drain() takes it down
    task automatic send_word(logic [1:0] fn, logic [31:0] req, logic [31:0] ptr,
                             logic [2:0] st_fix = ST_ANY, logic [31:0] addr_fix = '0);
        t_reply r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= fn;
        i_request_bytes <= req;
        i_pointer       <= ptr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = heap_apply(fn, req, ptr);
        if (st_fix != ST_ANY && (r.status != st_fix || r.address != addr_fix)) begin
            $display("%0t: table row expected %0d/%h, predictor %0d/%h",
                     $time, st_fix, addr_fix, r.status, r.address);
            errors++;
        end
        replies_due.push_back(r);
        if (fn == FN_ALLOC && r.status == ST_OK) live_ptrs.push_back(r.address);
        if (fn == FN_INIT) live_ptrs.delete();
        @(negedge i_clk);
    endtask

    typedef struct {
        logic [1:0]  fn;
        logic [31:0] req;
        logic [31:0] ptr;
        logic [2:0]  st;
        logic [31:0] addr;
    } t_row;

    t_row plan[] = '{
        '{FN_FREE,  32'd0,          32'h0001_0018, ST_NOTHING, 32'd0},
        '{FN_ALLOC, 32'd0,          32'd0,         ST_OK,      32'h0001_0018},
        '{FN_ALLOC, 32'd1,          32'd0,         ST_OK,      32'h0001_0030},
        '{FN_ALLOC, 32'hFFFF_FFFF,  32'd0,         ST_NO_FIT,  32'd0},
        '{FN_ALLOC, 32'hFFFF_FFC1,  32'd0,         ST_NO_FIT,  32'd0},
        '{FN_ALLOC, 32'h0001_0000,  32'd0,         ST_NO_FIT,  32'd0},
        '{FN_FREE,  32'd0,          32'd0,         ST_BAD_PTR, 32'd0},
        '{FN_FREE,  32'd0,          32'hFFFF_FFFF, ST_BAD_PTR, 32'd0},
        '{FN_FREE,  32'd0,          32'h0000_FFFF, ST_BAD_PTR, 32'd0},
        '{FN_FREE,  32'd0,          32'h0001_0000, ST_BELOW,   32'd0},
        '{FN_FREE,  32'd0,          32'h0001_0019, ST_NOT_ALLOC, 32'd0},
        '{FN_FREE,  32'd0,          32'h0002_0000, ST_NOT_ALLOC, 32'd0},
        '{FN_FREE,  32'd0,          32'h0001_0030, ST_ANY,     32'd0},
        '{FN_FREE,  32'd0,          32'h0001_0018, ST_ANY,     32'd0},
        '{FN_NOP,   32'hFFFF_FFFF,  32'hFFFF_FFFF, ST_OK,      32'd0},
        '{FN_ALLOC, 32'd200,        32'd0,         ST_ANY,     32'd0},
        '{FN_INIT,  32'hAAAA_5555,  32'h5555_AAAA, ST_OK,      32'd0},
        '{FN_ALLOC, 32'd65000,      32'd0,         ST_ANY,     32'd0}
    };

    // mostly alloc/free of live blocks, some noise
    task automatic random_word(int big);
        int pick;
        logic [31:0] req, ptr;
        pick = $urandom_range(99);
        if (pick < 48) begin
            req = (pick < 3) ? $urandom() : $urandom_range(big);
            send_word(FN_ALLOC, req, $urandom());
        end else if (pick < 88 && live_ptrs.size() != 0) begin
            int k;
            k = $urandom_range(live_ptrs.size() - 1);
            ptr = live_ptrs[k];
            live_ptrs.delete(k);
            send_word(FN_FREE, $urandom(), ptr);
        end else if (pick < 95) begin
            ptr = (pick & 1) ? $urandom() : hp_start + $urandom_range(4096);
            send_word(FN_FREE, $urandom(), ptr);
        end else if (pick < 97) begin
            send_word(FN_INIT, $urandom(), $urandom());
        end else begin
            send_word(FN_NOP, $urandom(), $urandom());
        end
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = '0;
        i_request_bytes = '0;
        i_pointer = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hp_start = 32'h0001_0000;
        hp_end   = 32'h0002_0000;
        heap_rebuild();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[n]) send_word(plan[n].fn, plan[n].req, plan[n].ptr, plan[n].st, plan[n].addr);
        drain();

        // heap too small, then at top of address space
        apb_write(REG_HEAP_START, 32'h0000_1000);
        apb_write(REG_HEAP_END,   32'h0000_1010);
        send_word(FN_INIT, 0, 0, ST_OK);
        send_word(FN_ALLOC, 0, 0, ST_NO_FIT);
        send_word(FN_FREE, 0, 32'h1018, ST_NOTHING);
        drain();
        apb_write(REG_HEAP_START, 32'hFFFF_F000);
        apb_write(REG_HEAP_END,   32'hFFFF_FFFF);
        send_word(FN_INIT, 0, 0, ST_OK);
        for (int n = 0; n < 6; n++) send_word(FN_ALLOC, $urandom_range(1500), 0);
        send_word(FN_FREE, 0, 32'hFFFF_FFFF);
        drain();

        // small heap pressure: long receiver hold, table full
        apb_write(REG_HEAP_START, 32'h0000_0000);
        apb_write(REG_HEAP_END,   32'h0000_2000);
        send_word(FN_INIT, 0, 0, ST_OK);
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            for (int n = 0; n < 70; n++) send_word(FN_ALLOC, $urandom_range(1), 0);
        join
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 73 : 0;
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 15 : 0;
            if (ph == 1) begin
                apb_write(REG_HEAP_START, 32'h8000_0000);
                apb_write(REG_HEAP_END,   32'h8000_4000);
            end else if (ph == 2) begin
                apb_write(REG_HEAP_START, 32'h0001_0000);
                apb_write(REG_HEAP_END,   32'h0002_0000);
            end
            send_word(FN_INIT, 0, 0, ST_OK);
            for (int n = 0; n < 370; n++) begin
                random_word(ph == 1 ? 700 : 3000);
                if (n == 200) drain();
            end
            drain();
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
